/* rtl/core/mlqpp_pkg.sv */
// Package with the slot table entry type and the constants of the multilevel queue picker.
`default_nettype none
package mlqpp_pkg;

  localparam int Slots = 64;
  localparam int SlotW = $clog2(Slots);
  localparam int CntW = $clog2(Slots + 1);
  localparam int RankW = 52;

  localparam logic [2:0] KindCreate = 3'd0;
  localparam logic [2:0] KindSetQueue = 3'd1;
  localparam logic [2:0] KindSetPrio = 3'd2;
  localparam logic [2:0] KindSetWeights = 3'd3;
  localparam logic [2:0] KindSetRun = 3'd4;
  localparam logic [2:0] KindYield = 3'd5;
  localparam logic [2:0] KindPick = 3'd6;

  localparam logic signed [31:0] RrFloor = -32'sd100000;
  localparam logic [RankW-1:0] RankLimit = RankW'(64'd10000000);
  localparam logic [30:0] FcfsLimit = 31'd2000000000;

  typedef struct packed {
    logic [1:0]  queue;
    logic [9:0]  prio;
    logic [30:0] created;
    logic [30:0] last_run;
    logic [15:0] exec_tenths;
    logic [15:0] pw;
    logic [15:0] aw;
    logic [15:0] ew;
  } entry_t;

endpackage
`default_nettype wire

/* rtl/core/multilevel_queue_process_picker.sv */
// Top level of the multilevel queue picker: slot table memory, pick scan and result register.
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o   | kind, slot, time_now, level, weights, flag
//   out     | output    | out_valid_o / out_stall_i | picked_valid, picked_slot, picked_level
//
// A pick reads one table entry per cycle from the slot memory.
// Every other word steps through memory read, write back and result load.
// Reset clears the runnable flags and the control state; the table itself is not cleared.
// A finished result waits in the output register while the next input word is taken.
`default_nettype none
module multilevel_queue_process_picker import mlqpp_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  kind_i,
  input  wire logic [5:0]  slot_i,
  input  wire logic [30:0] time_now_i,
  input  wire logic [2:0]  queue_level_i,
  input  wire logic [9:0]  priority_value_i,
  input  wire logic [15:0] priority_weight_i,
  input  wire logic [15:0] arrival_weight_i,
  input  wire logic [15:0] executed_weight_i,
  input  wire logic        runnable_value_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic             picked_valid_o,
  output logic [5:0]       picked_slot_o,
  output logic [2:0]       picked_level_o
);

  typedef enum logic [1:0] {Idle, Scan, Upd, Done} state_e;

  state_e state_q;
  entry_t mem [Slots];
  entry_t rdata_q;
  entry_t wdata;
  logic [SlotW-1:0] rd_addr;
  logic we;
  logic [Slots-1:0] runnable_q;

  logic [2:0]  kind_q;
  logic [5:0]  slot_q;
  logic [30:0] now_q;
  logic [2:0]  lvl_q;
  logic [9:0]  prio_q;
  logic [15:0] pw_q, aw_q, ew_q;
  logic        rv_q;

  logic [CntW-1:0] scan_q;
  logic            issue;
  logic            s1_vld_q, s1_run_q;
  logic [SlotW-1:0] s1_idx_q;
  logic            s2_vld_q, s2_run_q;
  logic [SlotW-1:0] s2_idx_q;
  logic [1:0]  s2_queue_q;
  logic [9:0]  s2_prio_q;
  logic [30:0] s2_created_q, s2_last_q;
  logic [25:0] p_pw_q;
  logic [46:0] p_aw_q;
  logic [31:0] p_ew_q;

  logic [3:0] found_q;
  logic [SlotW-1:0] best_q [4];
  logic signed [31:0] bgap_q;
  logic [9:0] bprio_q;
  logic [RankW-1:0] brank_q;
  logic [30:0] bcreated_q;

  logic signed [31:0] gap;
  logic [47:0] rank_sum;
  logic [RankW-1:0] rank;
  logic [RankW-1:0] rank_bound;
  logic [30:0] fcfs_bound;

  logic res_valid;
  logic [SlotW-1:0] res_slot;
  logic [2:0] res_level;
  logic out_free;

  assign in_stall_o = (state_q != Idle);
  assign issue = (state_q == Scan) && (scan_q < CntW'(Slots));
  assign out_free = !out_valid_o || !out_stall_i;

  always_comb begin
    rd_addr = slot_i;
    if (state_q == Scan) begin
      rd_addr = scan_q[SlotW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_q <= mem[rd_addr];
    if (we) begin
      mem[slot_q] <= wdata;
    end
  end

  always_comb begin
    wdata = rdata_q;
    we = 1'b0;
    if (state_q == Upd) begin
      case (kind_q)
        KindCreate: begin
          we = 1'b1;
          wdata.queue = 2'd0;
          wdata.prio = prio_q;
          wdata.created = now_q;
          wdata.last_run = 31'd0;
          wdata.exec_tenths = 16'd0;
          wdata.pw = 16'd1;
          wdata.aw = 16'd1;
          wdata.ew = 16'd1;
        end
        KindSetQueue: begin
          we = (lvl_q >= 3'd1) && (lvl_q <= 3'd4);
          wdata.queue = 2'(lvl_q - 3'd1);
        end
        KindSetPrio: begin
          we = 1'b1;
          wdata.prio = prio_q;
        end
        KindSetWeights: begin
          we = 1'b1;
          wdata.pw = pw_q;
          wdata.aw = aw_q;
          wdata.ew = ew_q;
        end
        KindYield: begin
          we = 1'b1;
          wdata.last_run = now_q;
          if (rdata_q.exec_tenths != 16'hFFFF) begin
            wdata.exec_tenths = rdata_q.exec_tenths + 16'd1;
          end
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    gap = $signed({1'b0, now_q}) - $signed({1'b0, s2_last_q});
    rank_sum = 48'(p_pw_q) + 48'(p_aw_q);
    rank = RankW'({rank_sum, 3'b000}) + RankW'({rank_sum, 1'b0}) + RankW'(p_ew_q);
    rank_bound = found_q[2] ? brank_q : RankLimit;
    fcfs_bound = found_q[3] ? bcreated_q : FcfsLimit;
  end

  always_comb begin
    res_valid = 1'b0;
    res_slot = '0;
    res_level = 3'd0;
    if (kind_q == KindPick) begin
      for (int l = 3; l >= 0; l--) begin
        if (found_q[l]) begin
          res_valid = 1'b1;
          res_slot = best_q[l];
          res_level = 3'(l + 1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      runnable_q <= '0;
    end else if (state_q == Upd) begin
      case (kind_q)
        KindCreate: runnable_q[slot_q] <= 1'b0;
        KindSetRun: runnable_q[slot_q] <= rv_q;
        KindYield:  runnable_q[slot_q] <= 1'b1;
        default:    runnable_q <= runnable_q;
      endcase
    end else if (state_q == Done && out_free && res_valid) begin
      runnable_q[res_slot] <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_idx_q <= scan_q[SlotW-1:0];
    s1_run_q <= runnable_q[scan_q[SlotW-1:0]];
    s2_run_q <= s1_run_q;
    s2_idx_q <= s1_idx_q;
    s2_queue_q <= rdata_q.queue;
    s2_prio_q <= rdata_q.prio;
    s2_created_q <= rdata_q.created;
    s2_last_q <= rdata_q.last_run;
    p_pw_q <= rdata_q.prio * rdata_q.pw;
    p_aw_q <= rdata_q.created * rdata_q.aw;
    p_ew_q <= rdata_q.exec_tenths * rdata_q.ew;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= Idle;
      scan_q <= '0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      found_q <= '0;
      out_valid_o <= 1'b0;
      picked_valid_o <= 1'b0;
      picked_slot_o <= '0;
      picked_level_o <= '0;
      kind_q <= '0;
    end else begin
      if (out_valid_o && !out_stall_i && state_q != Done) begin
        out_valid_o <= 1'b0;
      end
      s1_vld_q <= issue;
      s2_vld_q <= s1_vld_q;
      case (state_q)
        Idle: begin
          if (in_valid_i) begin
            kind_q <= kind_i;
            slot_q <= slot_i;
            now_q <= time_now_i;
            lvl_q <= queue_level_i;
            prio_q <= priority_value_i;
            pw_q <= priority_weight_i;
            aw_q <= arrival_weight_i;
            ew_q <= executed_weight_i;
            rv_q <= runnable_value_i;
            found_q <= '0;
            bgap_q <= RrFloor;
            scan_q <= '0;
            state_q <= (kind_i == KindPick) ? Scan : Upd;
          end
        end
        Scan: begin
          if (issue) begin
            scan_q <= scan_q + CntW'(1);
          end
          if (s2_vld_q && s2_run_q) begin
            case (s2_queue_q)
              2'd0: begin
                if (gap > bgap_q) begin
                  bgap_q <= gap;
                  best_q[0] <= s2_idx_q;
                  found_q[0] <= 1'b1;
                end
              end
              2'd1: begin
                if (!found_q[1] || s2_prio_q < bprio_q) begin
                  bprio_q <= s2_prio_q;
                  best_q[1] <= s2_idx_q;
                  found_q[1] <= 1'b1;
                end
              end
              2'd2: begin
                if (rank < rank_bound) begin
                  brank_q <= rank;
                  best_q[2] <= s2_idx_q;
                  found_q[2] <= 1'b1;
                end
              end
              default: begin
                if (s2_created_q < fcfs_bound) begin
                  bcreated_q <= s2_created_q;
                  best_q[3] <= s2_idx_q;
                  found_q[3] <= 1'b1;
                end
              end
            endcase
          end
          if (!issue && !s1_vld_q && !s2_vld_q) begin
            state_q <= Done;
          end
        end
        Upd: begin
          state_q <= Done;
        end
        Done: begin
          if (out_free) begin
            out_valid_o <= 1'b1;
            picked_valid_o <= res_valid;
            picked_slot_o <= res_slot;
            picked_level_o <= res_level;
            state_q <= Idle;
          end
        end
        default: begin
          state_q <= Idle;
        end
      endcase
    end
  end

  a_level_with_pick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    picked_valid_o |-> (picked_level_o != 3'd0 && picked_level_o <= 3'd4))
    else $error("picked word without a valid level");

  a_empty_is_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !picked_valid_o) |-> (picked_slot_o == '0 && picked_level_o == 3'd0))
    else $error("empty result word carries a slot or level");

  a_scan_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_vld_q || s2_vld_q) |-> (state_q == Scan))
    else $error("scan pipeline busy outside a pick");

  a_picked_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == Done && out_free && res_valid) |=> !runnable_q[$past(res_slot)])
    else $error("picked slot still runnable");

endmodule
`default_nettype wire

/* verif/multilevel_queue_process_picker_chk.sv */
// Checker that predicts every result word of the multilevel queue picker, picks and updates alike, and compares it.
module multilevel_queue_process_picker_chk import mlqpp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  logic [2:0]  kind_i,
  input  logic [5:0]  slot_i,
  input  logic [30:0] time_now_i,
  input  logic [2:0]  queue_level_i,
  input  logic [9:0]  priority_value_i,
  input  logic [15:0] priority_weight_i,
  input  logic [15:0] arrival_weight_i,
  input  logic [15:0] executed_weight_i,
  input  logic        runnable_value_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  logic        picked_valid_i,
  input  logic [5:0]  picked_slot_i,
  input  logic [2:0]  picked_level_i,
  output int          errors_o,
  output int          pending_o
);

  typedef struct packed {
    logic       found;
    logic [5:0] slot;
    logic [2:0] level;
  } pick_t;

  entry_t table_q [Slots];
  logic   ready_q [Slots];
  pick_t  expected_picks [$];

  localparam longint unsigned RankCap = 64'd10000000;
  localparam longint unsigned FirstCap = 64'd2000000000;
  localparam longint RrStart = -64'sd100000;

  task automatic report(input string what, input int got, input int want);
    $display("mismatch %s: got %0d, expected %0d (time %0t)", what, got, want, $time);
    errors_o++;
  endtask

  function automatic pick_t choose_slot(input logic [30:0] now);
    pick_t res;
    longint best_gap;
    longint unsigned best_val, v, cap;
    logic found;
    int best;
    res = '0;
    for (int lvl = 1; lvl <= 4; lvl++) begin
      found = 1'b0;
      best = 0;
      best_gap = RrStart;
      best_val = 0;
      for (int i = 0; i < Slots; i++) begin
        if (ready_q[i] && int'(table_q[i].queue) + 1 == lvl) begin
          if (lvl == 1) begin
            v = 0;
            if (longint'(now) - longint'(table_q[i].last_run) > best_gap) begin
              best_gap = longint'(now) - longint'(table_q[i].last_run);
              best = i;
              found = 1'b1;
            end
          end else begin
            if (lvl == 2) begin
              v = table_q[i].prio;
              cap = FirstCap;
            end else if (lvl == 3) begin
              v = 64'd10 * table_q[i].prio * table_q[i].pw
                + 64'd10 * table_q[i].created * table_q[i].aw
                + 64'(table_q[i].exec_tenths) * table_q[i].ew;
              cap = RankCap;
            end else begin
              v = table_q[i].created;
              cap = FirstCap;
            end
            if (v < (found ? best_val : cap)) begin
              best_val = v;
              best = i;
              found = 1'b1;
            end
          end
        end
      end
      if (found && !res.found) begin
        res.found = 1'b1;
        res.slot = 6'(best);
        res.level = 3'(lvl);
      end
    end
    if (res.found) ready_q[res.slot] = 1'b0;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t want;
    if (!rst_ni) begin
      for (int i = 0; i < Slots; i++) ready_q[i] = 1'b0;
      expected_picks.delete();
      errors_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_picks.size() == 0) begin
          report("result word count", 1, 0);
        end else begin
          want = expected_picks.pop_front();
          if (picked_valid_i !== want.found) report("picked_valid", picked_valid_i, want.found);
          if (picked_slot_i !== want.slot) report("picked_slot", picked_slot_i, want.slot);
          if (picked_level_i !== want.level) report("picked_level", picked_level_i, want.level);
        end
      end
      if (in_valid_i && !in_stall_i) begin
        want = '0;
        case (kind_i)
          KindCreate: begin
            table_q[slot_i] = '{queue: 2'd0, prio: priority_value_i, created: time_now_i,
                                last_run: 31'd0, exec_tenths: 16'd0,
                                pw: 16'd1, aw: 16'd1, ew: 16'd1};
            ready_q[slot_i] = 1'b0;
          end
          KindSetQueue:
            if (queue_level_i >= 3'd1 && queue_level_i <= 3'd4)
              table_q[slot_i].queue = 2'(queue_level_i - 3'd1);
          KindSetPrio: table_q[slot_i].prio = priority_value_i;
          KindSetWeights: begin
            table_q[slot_i].pw = priority_weight_i;
            table_q[slot_i].aw = arrival_weight_i;
            table_q[slot_i].ew = executed_weight_i;
          end
          KindSetRun: ready_q[slot_i] = runnable_value_i;
          KindYield: begin
            ready_q[slot_i] = 1'b1;
            table_q[slot_i].last_run = time_now_i;
            if (table_q[slot_i].exec_tenths != 16'hFFFF)
              table_q[slot_i].exec_tenths = table_q[slot_i].exec_tenths + 16'd1;
          end
          KindPick: want = choose_slot(time_now_i);
          default: ;
        endcase
        expected_picks.push_back(want);
      end
    end
    pending_o = expected_picks.size();
  end

endmodule

/* verif/multilevel_queue_process_picker_tb.sv */
// Testbench top of the multilevel queue picker: clock, reset, word stimulus and verdict.
module multilevel_queue_process_picker_tb import mlqpp_pkg::*;;

  localparam logic [2:0] KindNone = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  kind = '0;
  logic [5:0]  slot = '0;
  logic [30:0] time_now = '0;
  logic [2:0]  queue_level = '0;
  logic [9:0]  priority_value = '0;
  logic [15:0] priority_weight = '0;
  logic [15:0] arrival_weight = '0;
  logic [15:0] executed_weight = '0;
  logic        runnable_value = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        picked_valid;
  logic [5:0]  picked_slot;
  logic [2:0]  picked_level;
  int          errors, pending;
  logic        quiet = 1'b0;
  logic        hold_req = 1'b0;
  logic        hold_seen = 1'b0;
  int          hold_left = 0;
  logic        created [Slots];
  logic [30:0] clock_ticks = '0;

  always #6 clk_i = ~clk_i;

  multilevel_queue_process_picker u_dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall),
    .kind_i(kind), .slot_i(slot), .time_now_i(time_now), .queue_level_i(queue_level),
    .priority_value_i(priority_value), .priority_weight_i(priority_weight),
    .arrival_weight_i(arrival_weight), .executed_weight_i(executed_weight),
    .runnable_value_i(runnable_value),
    .out_valid_o(out_valid), .out_stall_i(out_stall),
    .picked_valid_o(picked_valid), .picked_slot_o(picked_slot),
    .picked_level_o(picked_level)
  );

  multilevel_queue_process_picker_chk u_chk (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall),
    .kind_i(kind), .slot_i(slot), .time_now_i(time_now), .queue_level_i(queue_level),
    .priority_value_i(priority_value), .priority_weight_i(priority_weight),
    .arrival_weight_i(arrival_weight), .executed_weight_i(executed_weight),
    .runnable_value_i(runnable_value),
    .out_valid_i(out_valid), .out_stall_i(out_stall),
    .picked_valid_i(picked_valid), .picked_slot_i(picked_slot),
    .picked_level_i(picked_level),
    .errors_o(errors), .pending_o(pending)
  );

  always @(negedge clk_i) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= 400;
      out_stall <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < 28);
    end
  end

  task automatic send_word(input logic [2:0] k, input logic [5:0] s, input logic [30:0] t,
                           input logic [2:0] q, input logic [9:0] p, input logic [15:0] pw,
                           input logic [15:0] aw, input logic [15:0] ew, input logic r);
    while (!quiet && $urandom_range(99) < 28) begin
      in_valid = 1'b0;
      @(negedge clk_i);
    end
    in_valid = 1'b1;
    kind = k; slot = s; time_now = t; queue_level = q; priority_value = p;
    priority_weight = pw; arrival_weight = aw; executed_weight = ew; runnable_value = r;
    if (k == KindCreate) created[s] = 1'b1;
    do @(posedge clk_i); while (in_stall);
    @(negedge clk_i);
    in_valid = 1'b0;
  endtask

  task automatic random_word();
    logic [2:0] k;
    logic [5:0] s;
    logic [30:0] t;
    logic [15:0] pw, aw, ew;
    logic r;
    int roll;
    roll = $urandom_range(99);
    if (roll < 10) k = KindCreate;
    else if (roll < 22) k = KindSetQueue;
    else if (roll < 30) k = KindSetPrio;
    else if (roll < 40) k = KindSetWeights;
    else if (roll < 50) k = KindSetRun;
    else if (roll < 74) k = KindYield;
    else if (roll < 98) k = KindPick;
    else k = KindNone;
    s = ($urandom_range(3) == 0) ? 6'($urandom_range(63)) : 6'($urandom_range(7));
    r = $urandom_range(1);
    if (!created[s] && (k == KindYield || (k == KindSetRun && r))) k = KindCreate;
    if ($urandom_range(9) == 0) t = 31'($urandom);
    else if (k == KindCreate && $urandom_range(1)) t = 31'($urandom_range(200000));
    else begin
      clock_ticks = clock_ticks + 31'($urandom_range(60000));
      t = clock_ticks;
    end
    if ($urandom_range(1)) begin
      pw = 16'($urandom_range(3)); aw = 16'($urandom_range(3)); ew = 16'($urandom_range(3));
    end else begin
      pw = 16'($urandom); aw = 16'($urandom); ew = 16'($urandom);
    end
    send_word(k, s, t, ($urandom_range(9) == 0) ? 3'($urandom_range(7))
              : 3'($urandom_range(4, 1)), 10'($urandom), pw, aw, ew, r);
  endtask

  initial begin
    for (int i = 0; i < Slots; i++) created[i] = 1'b0;
    repeat (12) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // Directed words: field extremes, each kind, bad levels and the unknown kind.
    send_word(KindPick, 6'd0, 31'd0, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindCreate, 6'd0, 31'd0, 3'd1, 10'd1023, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindCreate, 6'd63, 31'h7FFFFFFF, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindCreate, 6'd5, 31'd100, 3'd1, 10'd3, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindSetWeights, 6'd0, 31'd0, 3'd1, 10'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b0);
    send_word(KindSetQueue, 6'd63, 31'd0, 3'd4, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindSetQueue, 6'd0, 31'd0, 3'd0, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindSetQueue, 6'd0, 31'd0, 3'd7, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindSetQueue, 6'd5, 31'd0, 3'd3, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindYield, 6'd0, 31'd5, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindYield, 6'd63, 31'h7FFFFFFF, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindYield, 6'd5, 31'd7, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindNone, 6'd5, 31'd7, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_word(KindPick, 6'd63, 31'd200000, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindPick, 6'd0, 31'd10, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindSetPrio, 6'd5, 31'd0, 3'd1, 10'd1023, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindSetQueue, 6'd5, 31'd0, 3'd2, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindSetRun, 6'd5, 31'd0, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b1);
    send_word(KindPick, 6'd0, 31'h7FFFFFFF, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindSetRun, 6'd0, 31'd0, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_word(KindPick, 6'd0, 31'd0, 3'd1, 10'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    for (int n = 0; n < 750; n++) begin
      if (n == 200) hold_req = !hold_req;
      if (n == 400) wait (pending == 0);
      if (n == 500) quiet = 1'b1;
      if (n == 600) quiet = 1'b0;
      random_word();
    end
    wait (pending == 0);
    repeat (100) @(negedge clk_i);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #12000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/core/mlqpp_pkg.sv
rtl/core/multilevel_queue_process_picker.sv
verif/multilevel_queue_process_picker_chk.sv
verif/multilevel_queue_process_picker_tb.sv
